// ----- sv/uce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uce_pkg
// Shared types for the USB control endpoint stage sequencer: the event and
// result transaction layouts, the endpoint stage codes and the state record.
// ----------------------------------------------------------------------------
package uce_pkg;

  // Width of the IN byte counters; follows the reply_len field.
  localparam int unsigned IN_W = 9;

  // A valid setup packet is always eight bytes long.
  localparam logic [9:0] SETUP_BYTES = 10'd8;

  typedef enum logic [1:0] {
    EV_SETUP   = 2'd0,
    EV_OUT     = 2'd1,
    EV_IN      = 2'd2,
    EV_BUS_RST = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_STALL      = 3'd0,
    ST_DATA_IN    = 3'd1,
    ST_LAST_IN    = 3'd2,
    ST_DATA_OUT   = 3'd3,
    ST_LAST_OUT   = 3'd4,
    ST_STATUS_IN  = 3'd5,
    ST_STATUS_OUT = 3'd6
  } stage_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  rx_count;
    logic        dir_in;
    logic [15:0] req_length;
    logic        handler_reject;
    logic [8:0]  reply_len;
    logic        data_refused;
  } item_t;

  typedef struct packed {
    logic [2:0]  ep_stage;
    logic        tx_load;
    logic [8:0]  tx_offset;
    logic [6:0]  tx_len;
    logic        rx_copy;
    logic [15:0] rx_offset;
    logic        deliver_data;
    logic        status_done;
    logic        reset_done;
  } result_t;

  typedef struct packed {
    stage_t            stage;
    logic [IN_W-1:0]   in_left;
    logic [IN_W-1:0]   in_pos;
    logic [15:0]       out_left;
    logic [15:0]       out_pos;
    logic              zlp_needed;
  } state_t;

endpackage
`default_nettype wire

// ----- sv/uce_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uce_step
// Combinational stage transition: takes the current endpoint state and one
// event, gives the next state and the result transaction for that event.
// ----------------------------------------------------------------------------
module uce_step #(
  parameter int MAX_PACKET  = 64,
  parameter int REPLY_BYTES = 256
) (
  input  wire uce_pkg::state_t cur,
  input  wire uce_pkg::item_t  item,
  output uce_pkg::state_t      nxt,
  output uce_pkg::result_t     res
);

  localparam int unsigned IW = uce_pkg::IN_W;
  localparam logic [IW-1:0] MP_IN   = IW'(MAX_PACKET);
  localparam logic [15:0]   MP_OUT  = 16'(MAX_PACKET);
  localparam logic [9:0]    MP_RX   = 10'(MAX_PACKET);
  localparam logic [11:0]   RB_WIDE = 12'(REPLY_BYTES);
  localparam int            NMUL    = ((1 << IW) - 1) / MAX_PACKET + 1;

  logic [IW-1:0] rlen_sat;
  logic [IW-1:0] rlen;
  logic          rlen_mult;
  logic          setup_zlp;
  logic          setup_ok;

  // Shared IN packet builder; fed from the setup path or from the state.
  logic          snd_from_setup;
  logic [IW-1:0] snd_left;
  logic [IW-1:0] snd_pos;
  logic          snd_zlp;
  logic [IW-1:0] snd_n;
  logic [IW-1:0] snd_left_next;
  logic [IW-1:0] snd_pos_next;
  logic          snd_last;

  logic [15:0] out_left_sub;

  // Reply length: saturate to the buffer, then cut to the requested length.
  always_comb begin
    if ({{(12-IW){1'b0}}, item.reply_len} > RB_WIDE) begin
      rlen_sat = RB_WIDE[IW-1:0];
    end else begin
      rlen_sat = item.reply_len;
    end
    if ({{(16-IW){1'b0}}, rlen_sat} > item.req_length) begin
      rlen = item.req_length[IW-1:0];
    end else begin
      rlen = rlen_sat;
    end
  end

  // Whole number of packets: compare against every multiple that fits.
  always_comb begin
    rlen_mult = 1'b0;
    for (int k = 0; k < NMUL; k++) begin
      if (rlen == IW'(k * MAX_PACKET)) begin
        rlen_mult = 1'b1;
      end
    end
  end

  assign setup_zlp = ({{(16-IW){1'b0}}, rlen} < item.req_length) && rlen_mult;
  assign setup_ok  = (item.rx_count == uce_pkg::SETUP_BYTES) && !item.handler_reject;

  assign snd_from_setup = (item.kind == uce_pkg::EV_SETUP);
  assign snd_left       = snd_from_setup ? rlen      : cur.in_left;
  assign snd_pos        = snd_from_setup ? '0        : cur.in_pos;
  assign snd_zlp        = snd_from_setup ? setup_zlp : cur.zlp_needed;
  assign snd_n          = (snd_left < MP_IN) ? snd_left : MP_IN;
  assign snd_left_next  = snd_left - snd_n;
  assign snd_pos_next   = snd_pos + snd_n;
  assign snd_last       = (snd_n < MP_IN) || ((snd_left_next == '0) && !snd_zlp);

  assign out_left_sub = cur.out_left - MP_OUT;

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (uce_pkg::event_kind_t'(item.kind))
      uce_pkg::EV_SETUP: begin
        if (!setup_ok) begin
          nxt.stage = uce_pkg::ST_STALL;
        end else if (item.dir_in) begin
          nxt.zlp_needed = setup_zlp;
          nxt.in_left    = snd_left_next;
          nxt.in_pos     = snd_pos_next;
          nxt.stage      = snd_last ? uce_pkg::ST_LAST_IN : uce_pkg::ST_DATA_IN;
          res.tx_load    = 1'b1;
          res.tx_len     = snd_n[6:0];
        end else if (item.req_length != '0) begin
          nxt.out_pos  = '0;
          nxt.out_left = item.req_length;
          nxt.stage    = (item.req_length <= MP_OUT) ? uce_pkg::ST_LAST_OUT
                                                     : uce_pkg::ST_DATA_OUT;
        end else begin
          res.tx_load = 1'b1;
          nxt.stage   = uce_pkg::ST_STATUS_IN;
        end
      end
      uce_pkg::EV_OUT: begin
        if (cur.stage == uce_pkg::ST_DATA_OUT) begin
          if (item.rx_count != MP_RX) begin
            nxt.stage = uce_pkg::ST_STALL;
          end else begin
            res.rx_copy   = 1'b1;
            res.rx_offset = cur.out_pos;
            nxt.out_pos   = cur.out_pos + MP_OUT;
            nxt.out_left  = out_left_sub;
            nxt.stage     = (out_left_sub <= MP_OUT) ? uce_pkg::ST_LAST_OUT
                                                     : uce_pkg::ST_DATA_OUT;
          end
        end else if (cur.stage == uce_pkg::ST_LAST_OUT) begin
          if ({6'b0, item.rx_count} != cur.out_left) begin
            nxt.stage = uce_pkg::ST_STALL;
          end else begin
            res.rx_copy      = 1'b1;
            res.rx_offset    = cur.out_pos;
            res.deliver_data = 1'b1;
            if (item.data_refused) begin
              nxt.stage = uce_pkg::ST_STALL;
            end else begin
              res.tx_load = 1'b1;
              nxt.stage   = uce_pkg::ST_STATUS_IN;
            end
          end
        end else begin
          nxt.stage = uce_pkg::ST_STALL;
        end
      end
      uce_pkg::EV_IN: begin
        if (cur.stage == uce_pkg::ST_DATA_IN) begin
          nxt.in_left   = snd_left_next;
          nxt.in_pos    = snd_pos_next;
          nxt.stage     = snd_last ? uce_pkg::ST_LAST_IN : uce_pkg::ST_DATA_IN;
          res.tx_load   = 1'b1;
          res.tx_offset = cur.in_pos;
          res.tx_len    = snd_n[6:0];
        end else if (cur.stage == uce_pkg::ST_LAST_IN) begin
          nxt.stage = uce_pkg::ST_STATUS_OUT;
        end else begin
          res.status_done = (cur.stage == uce_pkg::ST_STATUS_IN);
          nxt.stage       = uce_pkg::ST_STALL;
        end
      end
      uce_pkg::EV_BUS_RST: begin
        res.reset_done = 1'b1;
        nxt.stage      = uce_pkg::ST_STALL;
      end
      default: begin
        nxt.stage = uce_pkg::ST_STALL;
      end
    endcase
    res.ep_stage = nxt.stage;
  end

endmodule
`default_nettype wire

// ----- sv/usb_control_endpoint_stages.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// usb_control_endpoint_stages
// Control endpoint stage sequencer: walks a control transfer through its
// setup, data and status stages, one bus event per transaction.
// ----------------------------------------------------------------------------

// Each event transaction (setup received, OUT done, IN done or bus reset)
// produces exactly one result transaction that carries the new endpoint
// stage, the IN packet to queue (offset and length in the reply buffer), the
// receive-buffer offset for OUT data, and strobes for the request handler.
// An event is captured in an input register, the transition logic works on
// it there and the result lands in an output register, so a result passes
// through both registers before it can be taken; one event can be taken in
// every cycle while the result side is not stalled. The endpoint state is
// updated in the same cycle the result is registered, so back-to-back events
// always see the state left by the one before. While the result register is
// held by a stall, the input register still fills once, and only then is
// the event side stalled. Bad setup sizes, wrong OUT packet sizes, handler
// rejections and events that do not fit the current stage all end in the
// stall stage; the byte counters and offsets are kept in that case.
module usb_control_endpoint_stages #(
  parameter int MAX_PACKET  = 64,
  parameter int REPLY_BYTES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ev_valid,
  output logic                  ev_stall,
  input  wire uce_pkg::item_t   ev_data,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output uce_pkg::result_t      res_data
);

  // Input register.
  logic            item_valid;
  uce_pkg::item_t  item;

  // Endpoint state and its next value.
  uce_pkg::state_t  state;
  uce_pkg::state_t  state_next;
  uce_pkg::result_t result_next;

  logic out_free;
  logic advance;

  // The result register can take a new value when it is empty or its
  // current transaction completes in this cycle.
  assign out_free = !res_valid || !res_stall;
  assign advance  = item_valid && out_free;
  assign ev_stall = item_valid && !out_free;

  uce_step #(
    .MAX_PACKET  (MAX_PACKET),
    .REPLY_BYTES (REPLY_BYTES)
  ) u_step (
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!ev_stall) begin
      item_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && !ev_stall) begin
      item <= ev_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= result_next;
    end
  end

  // The state only moves when an event is actually consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.stage      <= uce_pkg::ST_STALL;
      state.in_left    <= '0;
      state.in_pos     <= '0;
      state.out_left   <= '0;
      state.out_pos    <= '0;
      state.zlp_needed <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // A bus reset or a completed status stage always leaves the endpoint
  // stalled, waiting for the next setup.
  a_done_stalls: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.reset_done || res_data.status_done)
      |-> res_data.ep_stage == uce_pkg::ST_STALL)
    else $error("reset_done or status_done without stall stage");

  // A queued packet never exceeds one maximum packet.
  a_tx_len: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.tx_len <= 7'(MAX_PACKET))
    else $error("tx_len above MAX_PACKET");

  // A held event is not dropped while the result side is stalled.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !out_free |=> item_valid)
    else $error("pending event lost under output stall");

  // Registered stage follows the stage reported in the last result.
  a_stage_match: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_data.ep_stage == state.stage)
    else $error("result stage and endpoint state disagree");

endmodule
`default_nettype wire

// ----- tb/usb_control_endpoint_stages_tb.sv -----
// ----------------------------------------------------------------------------
// usb_control_endpoint_stages_tb
// Self-checking bench for the control endpoint stage sequencer. Bus events
// are sent through the event channel, every event is run through a local
// copy of the endpoint state machine, and each result transaction is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module usb_control_endpoint_stages_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT          = 64;      // max packet size of endpoint zero
  localparam int REPLY_MAX    = 256;     // size of the reply buffer
  localparam int ITEMS        = 950;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             ev_valid  = 1'b0;
  logic             ev_stall;
  uce_pkg::item_t   ev_data   = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  uce_pkg::result_t res_data;

  usb_control_endpoint_stages u_dut (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev_stall  (ev_stall),
    .ev_data   (ev_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always #1ns clk = ~clk;

  // Bus events waiting to be sent, and the results the endpoint owes us.
  uce_pkg::item_t   bus_events_q[$];
  uce_pkg::result_t ep_answers_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned total_events  = 0;
  int unsigned taken_cnt     = 0;
  int unsigned fail_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  bit          ev_taken      = 1'b0;

  // Local view of the endpoint: current stage, the IN reply still to send
  // and its buffer position, the OUT data still expected and its receive
  // offset, and whether a closing zero-length packet is owed.
  uce_pkg::stage_t cur_stage    = uce_pkg::ST_STALL;
  logic [8:0]      tx_remaining = '0;
  logic [8:0]      tx_pos       = '0;
  logic [15:0]     rx_remaining = '0;
  logic [15:0]     rx_pos       = '0;
  logic            zlp_owed     = 1'b0;

  // Queue the next IN packet of the reply. A short packet ends the data
  // stage; a full one ends it only when the reply is used up and no
  // zero-length packet has to follow.
  function automatic void queue_in_packet(inout uce_pkg::result_t r);
    logic [8:0] n;
    n = (tx_remaining < PKT) ? tx_remaining : 9'(PKT);
    r.tx_load   = 1'b1;
    r.tx_offset = tx_pos;
    r.tx_len    = n[6:0];
    tx_pos       = tx_pos + n;
    tx_remaining = tx_remaining - n;
    if (n < PKT || (tx_remaining == 0 && !zlp_owed)) cur_stage = uce_pkg::ST_LAST_IN;
    else cur_stage = uce_pkg::ST_DATA_IN;
  endfunction

  // Advance the local endpoint by one bus event and return its result.
  function automatic uce_pkg::result_t advance_endpoint(uce_pkg::item_t ev);
    uce_pkg::result_t r;
    logic [8:0]       reply;
    r = '0;
    case (uce_pkg::event_kind_t'(ev.kind))
      uce_pkg::EV_SETUP: begin
        if (ev.rx_count != uce_pkg::SETUP_BYTES || ev.handler_reject) begin
          // Malformed or refused setups stall but keep counters and offsets.
          cur_stage = uce_pkg::ST_STALL;
        end else if (ev.dir_in) begin
          // The reply is clipped to the buffer first, then to wLength.
          reply = (ev.reply_len > REPLY_MAX) ? 9'(REPLY_MAX) : ev.reply_len;
          if (reply > ev.req_length) reply = ev.req_length[8:0];
          tx_remaining = reply;
          tx_pos       = '0;
          zlp_owed     = (reply < ev.req_length) && (reply % PKT == 0);
          queue_in_packet(r);
        end else if (ev.req_length != 0) begin
          rx_pos       = '0;
          rx_remaining = ev.req_length;
          cur_stage    = (ev.req_length <= PKT) ? uce_pkg::ST_LAST_OUT
                                                : uce_pkg::ST_DATA_OUT;
        end else begin
          // No data stage: the status packet goes out right away.
          r.tx_load = 1'b1;
          cur_stage = uce_pkg::ST_STATUS_IN;
        end
      end
      uce_pkg::EV_OUT: begin
        if (cur_stage == uce_pkg::ST_DATA_OUT) begin
          if (ev.rx_count != PKT) begin
            cur_stage = uce_pkg::ST_STALL;
          end else begin
            r.rx_copy    = 1'b1;
            r.rx_offset  = rx_pos;
            rx_pos       = rx_pos + 16'(PKT);
            rx_remaining = rx_remaining - 16'(PKT);
            cur_stage    = (rx_remaining <= PKT) ? uce_pkg::ST_LAST_OUT
                                                 : uce_pkg::ST_DATA_OUT;
          end
        end else if (cur_stage == uce_pkg::ST_LAST_OUT) begin
          if (ev.rx_count != rx_remaining) begin
            cur_stage = uce_pkg::ST_STALL;
          end else begin
            // The data reaches the handler even if it then refuses it.
            r.rx_copy      = 1'b1;
            r.rx_offset    = rx_pos;
            r.deliver_data = 1'b1;
            if (ev.data_refused) begin
              cur_stage = uce_pkg::ST_STALL;
            end else begin
              r.tx_load = 1'b1;
              cur_stage = uce_pkg::ST_STATUS_IN;
            end
          end
        end else begin
          cur_stage = uce_pkg::ST_STALL;
        end
      end
      uce_pkg::EV_IN: begin
        if (cur_stage == uce_pkg::ST_DATA_IN) begin
          queue_in_packet(r);
        end else if (cur_stage == uce_pkg::ST_LAST_IN) begin
          cur_stage = uce_pkg::ST_STATUS_OUT;
        end else begin
          if (cur_stage == uce_pkg::ST_STATUS_IN) r.status_done = 1'b1;
          cur_stage = uce_pkg::ST_STALL;
        end
      end
      default: begin
        // Bus reset keeps counters and offsets.
        r.reset_done = 1'b1;
        cur_stage    = uce_pkg::ST_STALL;
      end
    endcase
    r.ep_stage = cur_stage;
    return r;
  endfunction

  // An event of the given kind with every other field random, so that the
  // fields the endpoint ignores still see all their bits toggle.
  function automatic uce_pkg::item_t rand_event(uce_pkg::event_kind_t k);
    logic [63:0]    raw;
    uce_pkg::item_t it;
    raw     = {$urandom, $urandom};
    it      = raw[$bits(uce_pkg::item_t)-1:0];
    it.kind = k;
    return it;
  endfunction

  function automatic uce_pkg::item_t setup_event(logic dir, logic [15:0] wlen,
                                                 logic [8:0] reply);
    uce_pkg::item_t it;
    it                = rand_event(uce_pkg::EV_SETUP);
    it.rx_count       = uce_pkg::SETUP_BYTES;
    it.handler_reject = 1'b0;
    it.dir_in         = dir;
    it.req_length     = wlen;
    it.reply_len      = reply;
    return it;
  endfunction

  function automatic uce_pkg::item_t out_event(logic [9:0] rx, logic refused);
    uce_pkg::item_t it;
    it              = rand_event(uce_pkg::EV_OUT);
    it.rx_count     = rx;
    it.data_refused = refused;
    return it;
  endfunction

  task automatic build_directed();
    uce_pkg::item_t it;
    bus_events_q.push_back(rand_event(uce_pkg::EV_BUS_RST));
    bus_events_q.push_back(rand_event(uce_pkg::EV_IN));   // IN while stalled
    bus_events_q.push_back(out_event(10'd64, 1'b0));      // OUT while stalled
    // Setup packets of the wrong size and one the handler rejects.
    it = setup_event(1'b1, 16'd18, 9'd18);
    it.rx_count = '0;
    bus_events_q.push_back(it);
    it.rx_count = '1;
    bus_events_q.push_back(it);
    it = setup_event(1'b1, 16'd18, 9'd18);
    it.handler_reject = 1'b1;
    bus_events_q.push_back(it);
    // Oversized reply cut to the buffer, four full packets, then a
    // zero-length packet, the status stage, and an IN in status-out.
    bus_events_q.push_back(setup_event(1'b1, 16'hFFFF, 9'h1FF));
    repeat (6) bus_events_q.push_back(rand_event(uce_pkg::EV_IN));
    // Empty reply to an empty request, then an OUT in status-out.
    bus_events_q.push_back(setup_event(1'b1, 16'd0, 9'd0));
    bus_events_q.push_back(rand_event(uce_pkg::EV_IN));
    bus_events_q.push_back(out_event(10'd0, 1'b0));
    // OUT request with no data stage, completed by the status IN.
    bus_events_q.push_back(setup_event(1'b0, 16'd0, 9'd0));
    bus_events_q.push_back(rand_event(uce_pkg::EV_IN));
    // Three-packet OUT transfer whose data the handler refuses.
    bus_events_q.push_back(setup_event(1'b0, 16'd130, 9'd0));
    bus_events_q.push_back(out_event(10'd64, 1'b0));
    bus_events_q.push_back(out_event(10'd64, 1'b0));
    bus_events_q.push_back(out_event(10'd2, 1'b1));
    // Exactly one packet goes straight to last-data-out; a short packet stalls.
    bus_events_q.push_back(setup_event(1'b0, 16'd64, 9'd0));
    bus_events_q.push_back(out_event(10'd63, 1'b0));
  endtask

  // One random control transfer, mostly well formed. A tenth of the calls
  // add plain noise events of any kind instead.
  task automatic add_transfer();
    uce_pkg::item_t it;
    int unsigned    pick;
    int unsigned    wlen;
    int unsigned    reply;
    int unsigned    n_in;
    int unsigned    left;
    int unsigned    n_out;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 3))
        bus_events_q.push_back(rand_event(uce_pkg::event_kind_t'($urandom_range(3))));
    end else if (pick < 55) begin
      case ($urandom_range(3))
        0:       wlen = $urandom_range(0, 300);
        1:       wlen = PKT * $urandom_range(0, 5);
        2:       wlen = $urandom_range(0, 65535);
        default: wlen = $urandom_range(1, 8);
      endcase
      case ($urandom_range(3))
        0:       reply = $urandom_range(0, 300);
        1:       reply = PKT * $urandom_range(0, 4);
        2:       reply = $urandom_range(0, 511);
        default: reply = (wlen > 511) ? 511 : wlen;
      endcase
      it = setup_event(1'b1, wlen[15:0], reply[8:0]);
      if ($urandom_range(19) == 0) it.handler_reject = 1'b1;
      if ($urandom_range(19) == 0) it.rx_count = 10'($urandom_range(0, 1023));
      bus_events_q.push_back(it);
      // Enough IN completions to walk through the data and status stages.
      if (reply > REPLY_MAX) reply = REPLY_MAX;
      if (reply > wlen) reply = wlen;
      n_in = reply / PKT + 2;
      if ($urandom_range(9) == 0) n_in = $urandom_range(0, n_in);
      repeat (n_in) bus_events_q.push_back(rand_event(uce_pkg::EV_IN));
      if ($urandom_range(1) == 0) bus_events_q.push_back(out_event(10'd0, 1'b0));
    end else begin
      case ($urandom_range(9))
        0, 1, 2:    wlen = 0;
        3, 4, 5, 6: wlen = $urandom_range(1, 300);
        7, 8:       wlen = PKT * $urandom_range(1, 5);
        default:    wlen = $urandom_range(0, 65535);
      endcase
      it = setup_event(1'b0, wlen[15:0], 9'($urandom_range(0, 511)));
      if ($urandom_range(19) == 0) it.handler_reject = 1'b1;
      bus_events_q.push_back(it);
      left  = wlen;
      n_out = 0;
      while (left > PKT && n_out < 8) begin
        it = out_event(10'(PKT), 1'($urandom_range(1)));
        if ($urandom_range(19) == 0) it.rx_count = 10'($urandom_range(0, 1023));
        bus_events_q.push_back(it);
        left  = left - PKT;
        n_out = n_out + 1;
      end
      if (wlen != 0) begin
        it = out_event(10'(left), 1'($urandom_range(6) == 0));
        if ($urandom_range(19) == 0) it.rx_count = 10'($urandom_range(0, 1023));
        bus_events_q.push_back(it);
      end
      bus_events_q.push_back(rand_event(uce_pkg::EV_IN));
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_cnt = fail_cnt + 1;
    end
  endtask

  // Driver: moves on to the next event only after the current one was taken
  // at the last rising edge, so a stalled payload never changes. The result
  // stall is redrawn on every falling edge.
  always @(negedge clk) begin
    if (rst) begin
      ev_valid  <= 1'b0;
      res_stall <= 1'b0;
    end else begin
      if (!ev_valid || ev_taken) begin
        if (bus_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev_valid <= 1'b1;
          ev_data  <= bus_events_q.pop_front();
        end else begin
          ev_valid <= 1'b0;
        end
      end
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: checks an accepted result against the oldest prediction, then
  // predicts the result of any event accepted at this edge. The result of an
  // event never comes out in the cycle it is accepted, so this order is safe.
  always @(posedge clk) begin : monitor_p
    uce_pkg::result_t want;
    if (rst) begin
      ev_taken = 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (ep_answers_q.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual %p",
                   $time, res_data);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = ep_answers_q.pop_front();
          check_field("ep_stage", 16'(want.ep_stage), 16'(res_data.ep_stage));
          check_field("tx_load", 16'(want.tx_load), 16'(res_data.tx_load));
          check_field("tx_offset", 16'(want.tx_offset), 16'(res_data.tx_offset));
          check_field("tx_len", 16'(want.tx_len), 16'(res_data.tx_len));
          check_field("rx_copy", 16'(want.rx_copy), 16'(res_data.rx_copy));
          check_field("rx_offset", want.rx_offset, res_data.rx_offset);
          check_field("deliver_data", 16'(want.deliver_data), 16'(res_data.deliver_data));
          check_field("status_done", 16'(want.status_done), 16'(res_data.status_done));
          check_field("reset_done", 16'(want.reset_done), 16'(res_data.reset_done));
        end
      end
      ev_taken = ev_valid && !ev_stall;
      if (ev_taken) begin
        ep_answers_q.push_back(advance_endpoint(ev_data));
        taken_cnt = taken_cnt + 1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[usb_control_endpoint_stages] ERROR");
      $finish;
    end
  end

  // Main sequence: build all stimulus up front, release reset, then run
  // three idling phases of equal length. The sender idles lightly against a
  // heavily stalling receiver first, then the roles swap, and the last third
  // runs at full rate on both sides.
  initial begin
    build_directed();
    while (bus_events_q.size() < ITEMS) add_transfer();
    total_events = bus_events_q.size();
    send_idle_pct = 16;
    recv_idle_pct = 61;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    while (taken_cnt < total_events / 3) @(posedge clk);
    send_idle_pct = 61;
    recv_idle_pct = 16;
    while (taken_cnt < 2 * total_events / 3) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (taken_cnt < total_events || ep_answers_q.size() != 0) @(posedge clk);
    // Keep the clock running to catch any result the endpoint should not send.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[usb_control_endpoint_stages] OK");
    end else begin
      $display("[usb_control_endpoint_stages] ERROR");
    end
    $finish;
  end

endmodule

// ----- usb_control_endpoint_stages.f -----
sv/uce_pkg.sv
sv/uce_step.sv
sv/usb_control_endpoint_stages.sv
tb/usb_control_endpoint_stages_tb.sv
